>>> rtl/core/rlztd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlztd_pkg
// Item types, status codes and format codes for the token stream decoder.
// ----------------------------------------------------------------------------
package rlztd_pkg;

	typedef enum logic [1:0] {
		STATUS_TOKEN    = 2'd0,
		STATUS_END      = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	localparam logic [1:0] MODE_WORD32  = 2'd0;
	localparam logic [1:0] MODE_WORD64  = 2'd1;
	localparam logic [1:0] MODE_VARBYTE = 2'd2;

	localparam int unsigned ACC_W   = 64;
	localparam int unsigned SHIFT_W = 6;
	localparam int unsigned BCNT_W  = 3;

	localparam logic [BCNT_W-1:0]  WORD32_LAST     = 3'd3;
	localparam logic [BCNT_W-1:0]  WORD64_LAST     = 3'd7;
	localparam logic [SHIFT_W:0]   GROUP_BITS      = 7'd7;
	localparam logic [SHIFT_W:0]   POS_SHIFT_LIMIT = 7'd64;
	localparam logic [SHIFT_W:0]   LEN_SHIFT_LIMIT = 7'd63;
	localparam int unsigned        CONT_BIT        = 7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} byte_item_t;

	typedef struct packed {
		logic [63:0]        token_position;
		logic signed [63:0] token_length;
		status_t            status;
	} token_item_t;

endpackage

>>> rtl/core/rlz_token_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlz_token_stream_decoder_unit
// Rebuilds (position, length) tokens from a byte stream in three encodings.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the byte channel (valid/ready), one item per cycle at full
//   rate. Each item carries one stream byte or an end-of-input mark. Tokens and
//   status items leave on the token channel (valid/ready), at most one result
//   per input item. cfg_we/cfg_wdata set the format: two 32-bit words, two
//   64-bit words or a LEB128 pair; a write drops any partial token.
//   An accepted item waits in the input register; the decode step then
//   updates the decoder state and loads any result into the result register.
//   Throughput is one item per cycle while the receiver takes results, set by
//   the single decode step between the input register and result register.
//   End of input gives a status item with zero values and restarts decoding;
//   an over-long varint gives an overflow status and restarts as well.
//   Reset clears the format to two 32-bit words and empties both registers.
//   When the receiver stalls, the result holds, one more item is taken into
//   the input register, and then ready drops until the result is taken.
// ----------------------------------------------------------------------------
module rlz_token_stream_decoder_unit
	import rlztd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  byte_item_t  byte_item,
	output logic        token_valid,
	input  logic        token_ready,
	output token_item_t token_item,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);

	logic               item_valid_s1;
	byte_item_t         item_s1;
	logic               advance;

	logic [1:0]         mode_q;
	logic [ACC_W-1:0]   pos_q, pos_n;
	logic [ACC_W-1:0]   len_q, len_n;
	logic [SHIFT_W-1:0] shift_q, shift_n;
	logic [BCNT_W-1:0]  bcnt_q, bcnt_n;
	logic               phase_q, phase_n;

	logic               emit;
	token_item_t        result;
	logic               out_valid_q;
	token_item_t        out_item_q;

	logic [7:0]         dbyte;
	logic [ACC_W-1:0]   fixed_ins;
	logic [ACC_W-1:0]   var_add;
	logic [SHIFT_W:0]   shift_sum;
	logic               word_last;

	assign advance    = item_valid_s1 && (!out_valid_q || token_ready);
	assign byte_ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
	end

	assign dbyte     = item_s1.data_byte;
	assign fixed_ins = {{(ACC_W-8){1'b0}}, dbyte} << {bcnt_q, 3'b000};
	assign var_add   = {{(ACC_W-8){1'b0}}, 1'b0, dbyte[CONT_BIT-1:0]} << shift_q;
	assign shift_sum = {1'b0, shift_q} + GROUP_BITS;
	assign word_last = (mode_q == MODE_WORD32) ? (bcnt_q == WORD32_LAST)
	                                           : (bcnt_q == WORD64_LAST);

	always_comb begin
		pos_n   = pos_q;
		len_n   = len_q;
		shift_n = shift_q;
		bcnt_n  = bcnt_q;
		phase_n = phase_q;
		emit    = 1'b0;
		result  = '{token_position: '0, token_length: '0, status: STATUS_TOKEN};
		if (item_s1.end_of_input) begin
			emit          = 1'b1;
			result.status = STATUS_END;
		end else begin
			case (mode_q)
				MODE_WORD32, MODE_WORD64: begin
					if (phase_q) len_n = len_q | fixed_ins;
					else         pos_n = pos_q | fixed_ins;
					if (!word_last) begin
						bcnt_n = bcnt_q + 1'b1;
					end else begin
						bcnt_n = '0;
						if (!phase_q) begin
							phase_n = 1'b1;
						end else begin
							emit                  = 1'b1;
							result.token_position = pos_n;
							result.token_length   = $signed(len_n);
						end
					end
				end
				MODE_VARBYTE: begin
					if (phase_q) len_n = len_q + var_add;
					else         pos_n = pos_q + var_add;
					if (dbyte[CONT_BIT]) begin
						shift_n = shift_sum[SHIFT_W-1:0];
						if (shift_sum >= (phase_q ? LEN_SHIFT_LIMIT : POS_SHIFT_LIMIT)) begin
							emit          = 1'b1;
							result.status = STATUS_OVERFLOW;
						end
					end else begin
						shift_n = '0;
						if (!phase_q) begin
							phase_n = 1'b1;
						end else begin
							emit                  = 1'b1;
							result.token_position = pos_n;
							result.token_length   = $signed(len_n);
						end
					end
				end
				default: begin
					// unused format code: drop the byte
				end
			endcase
		end
		if (emit) begin
			pos_n   = '0;
			len_n   = '0;
			shift_n = '0;
			bcnt_n  = '0;
			phase_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_WORD32;
			pos_q   <= '0;
			len_q   <= '0;
			shift_q <= '0;
			bcnt_q  <= '0;
			phase_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q  <= cfg_wdata;
			pos_q   <= '0;
			len_q   <= '0;
			shift_q <= '0;
			bcnt_q  <= '0;
			phase_q <= 1'b0;
		end else if (advance) begin
			pos_q   <= pos_n;
			len_q   <= len_n;
			shift_q <= shift_n;
			bcnt_q  <= bcnt_n;
			phase_q <= phase_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (token_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result until the receiver takes it
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_item_q <= result;
		end
	end

	assign token_valid = out_valid_q;
	assign token_item  = out_item_q;

	a_status_zero_values: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_item.status != STATUS_TOKEN) |->
			(token_item.token_position == '0) && (token_item.token_length == '0))
		else $error("status item carries nonzero values");

	a_cfg_clears_token: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !phase_q && (bcnt_q == '0) && (shift_q == '0) &&
			(pos_q == '0) && (len_q == '0))
		else $error("partial token survives a format write");

	a_ready_only_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> item_valid_s1 && token_valid && !token_ready)
		else $error("input stalled while the output is free");

endmodule

>>> test/tb_rlz_token_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rlz_token_stream_decoder_unit
// Self-checking bench for the token stream decoder in all four format codes.
// A short table covers end-of-input, varint overflow and the unused format.
// Random phases follow: word tokens, LEB128 pairs with overflow and cut-off
// tokens, under several idle and stall patterns. Every accepted byte item runs
// through a local decoder model, and each token item is compared field by
// field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_rlz_token_stream_decoder_unit;
	import rlztd_pkg::*;

	localparam int          CLK_HALF      = 6;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          PHASE_ITEMS   = 74;
	localparam int          HOLD_CYCLES   = 64;
	localparam logic [1:0]  MODE_UNUSED   = 2'd3;

	typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic [7:0] value;
		bit         eoi;
		int         reps;
		bit         has_lit;
		status_t    lit_st;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_ready;
	byte_item_t  byte_item;
	logic        token_valid;
	logic        token_ready;
	token_item_t token_item;
	logic        cfg_we;
	logic [1:0]  cfg_wdata;

	// decoder model state
	logic [1:0]  fmt_mode;
	logic [63:0] pos_acc;
	logic [63:0] len_acc;
	logic [6:0]  grp_shift;
	logic [3:0]  word_idx;
	logic        in_len;

	token_item_t pending_tokens[$];
	bit          lit_armed;
	token_item_t lit_token;
	int          mismatch_count;
	int          items_sent;
	int          send_idle_pct;
	int          stall_pct;
	int          hold_left;

	dir_row_t dir_table [10] = '{
		'{ROW_BYTE, 8'h00, 1'b1, 1, 1'b1, STATUS_END},
		'{ROW_CFG, 8'(MODE_VARBYTE), 1'b0, 0, 1'b0, STATUS_TOKEN},
		// position with ten continuation bytes
		'{ROW_BYTE, 8'h80, 1'b0, 9, 1'b0, STATUS_TOKEN},
		'{ROW_BYTE, 8'h80, 1'b0, 1, 1'b1, STATUS_OVERFLOW},
		// zero position, then a length with nine continuation bytes
		'{ROW_BYTE, 8'h00, 1'b0, 1, 1'b0, STATUS_TOKEN},
		'{ROW_BYTE, 8'hFF, 1'b0, 8, 1'b0, STATUS_TOKEN},
		'{ROW_BYTE, 8'hFF, 1'b0, 1, 1'b1, STATUS_OVERFLOW},
		'{ROW_CFG, 8'(MODE_UNUSED), 1'b0, 0, 1'b0, STATUS_TOKEN},
		'{ROW_BYTE, 8'hFF, 1'b0, 1, 1'b0, STATUS_TOKEN},
		'{ROW_BYTE, 8'h00, 1'b1, 1, 1'b1, STATUS_END}
	};

	logic [1:0] phase_mode [8] = '{MODE_WORD32, MODE_WORD64, MODE_VARBYTE, MODE_UNUSED,
		MODE_VARBYTE, MODE_WORD32, MODE_WORD64, MODE_VARBYTE};
	int phase_idle  [4] = '{0, 49, 0, 11};
	int phase_stall [4] = '{0, 0, 49, 11};

	rlz_token_stream_decoder_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.byte_item   (byte_item),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_item  (token_item),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	function automatic void clear_partial();
		pos_acc   = '0;
		len_acc   = '0;
		grp_shift = '0;
		word_idx  = '0;
		in_len    = 1'b0;
	endfunction

	// Advance the model by one byte item; return 1 when it yields a token item.
	function automatic bit decode_byte(input byte_item_t it, output token_item_t tok);
		logic [63:0] add;
		logic [5:0]  sh;
		logic [6:0]  lim;
		int unsigned wbytes;
		tok = '0;
		if (it.end_of_input) begin
			tok.status = STATUS_END;
			clear_partial();
			return 1'b1;
		end
		case (fmt_mode)
			MODE_WORD32, MODE_WORD64: begin
				wbytes = (fmt_mode == MODE_WORD32) ? 4 : 8;
				sh = {word_idx[2:0], 3'b000};
				if (in_len)
					len_acc |= 64'(it.data_byte) << sh;
				else
					pos_acc |= 64'(it.data_byte) << sh;
				if (word_idx + 1 < wbytes) begin
					word_idx = word_idx + 4'd1;
				end else begin
					word_idx = '0;
					if (!in_len) begin
						in_len = 1'b1;
					end else begin
						tok.token_position = pos_acc;
						tok.token_length   = len_acc;
						tok.status         = STATUS_TOKEN;
						clear_partial();
						return 1'b1;
					end
				end
			end
			MODE_VARBYTE: begin
				sh  = grp_shift[5:0];
				lim = in_len ? LEN_SHIFT_LIMIT : POS_SHIFT_LIMIT;
				// the group is the low seven bits whether or not the byte continues
				add = {57'd0, it.data_byte[6:0]};
				if (in_len)
					len_acc += add << sh;
				else
					pos_acc += add << sh;
				if (it.data_byte[CONT_BIT]) begin
					grp_shift = grp_shift + GROUP_BITS;
					if (grp_shift >= lim) begin
						tok.status = STATUS_OVERFLOW;
						clear_partial();
						return 1'b1;
					end
				end else begin
					grp_shift = '0;
					if (!in_len) begin
						in_len = 1'b1;
					end else begin
						tok.token_position = pos_acc;
						tok.token_length   = len_acc;
						tok.status         = STATUS_TOKEN;
						clear_partial();
						return 1'b1;
					end
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic note_mismatch(input string what, input token_item_t want);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: want pos %h len %h st %0d, got pos %h len %h st %0d",
				$realtime, what, want.token_position, want.token_length, want.status,
				token_item.token_position, token_item.token_length, token_item.status);
	endtask

	always @(posedge clk) begin
		token_item_t want;
		token_item_t made_tok;
		bit          made;
		if (arst_n) begin
			if (token_valid && token_ready) begin
				if (pending_tokens.size() == 0) begin
					note_mismatch("token with none pending", '0);
				end else begin
					want = pending_tokens.pop_front();
					if (token_item.token_position !== want.token_position ||
					    token_item.token_length !== want.token_length ||
					    token_item.status !== want.status)
						note_mismatch("token mismatch", want);
				end
			end
			if (cfg_we) begin
				fmt_mode = cfg_wdata;
				clear_partial();
			end
			if (byte_valid && byte_ready) begin
				made = decode_byte(byte_item, made_tok);
				if (made || lit_armed)
					pending_tokens.push_back(lit_armed ? lit_token : made_tok);
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		token_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				token_ready <= 1'b0;
			end else begin
				token_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit eoi, input bit has_lit,
			input status_t lit_st);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_item  <= '{data_byte: b, end_of_input: eoi};
		byte_valid <= 1'b1;
		lit_armed = has_lit;
		lit_token = '{token_position: '0, token_length: '0, status: lit_st};
		items_sent++;
		do @(posedge clk); while (!byte_ready);
	endtask

	task automatic send_data(input logic [7:0] b);
		send_byte(b, 1'b0, 1'b0, STATUS_TOKEN);
	endtask

	task automatic send_eoi();
		send_byte(8'($urandom_range(255)), 1'b1, 1'b0, STATUS_TOKEN);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic int varint_len(input int longest);
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return $urandom_range(1, 2);
		else if (r < 80)
			return $urandom_range(3, longest - 2);
		else
			return $urandom_range(longest - 1, longest);
	endfunction

	// runaway keeps the continuation bit on the last byte as well
	task automatic send_varint(input int nbytes, input bit runaway);
		logic [6:0] grp;
		for (int i = 0; i < nbytes; i++) begin
			case ($urandom_range(5))
				0:       grp = 7'h00;
				1:       grp = 7'h7F;
				default: grp = 7'($urandom_range(127));
			endcase
			send_data({(i < nbytes - 1) || runaway, grp});
		end
	endtask

	task automatic send_word_token(input int nbytes);
		for (int i = 0; i < 2 * nbytes; i++) begin
			if ($urandom_range(59) == 0) begin
				send_eoi();
				return;
			end
			send_data(rand_byte());
		end
	endtask

	task automatic send_varbyte_token();
		int r;
		r = $urandom_range(99);
		if (r < 6) begin
			send_varint($urandom_range(1, 8), 1'b1);
			send_eoi();
		end else if (r < 12) begin
			send_varint(10, 1'b1);
		end else if (r < 18) begin
			send_varint(varint_len(10), 1'b0);
			send_varint(9, 1'b1);
		end else begin
			send_varint(varint_len(10), 1'b0);
			send_varint(varint_len(9), 1'b0);
		end
	endtask

	// drop valid, wait out every pending token, then let the pipeline settle
	task automatic wait_drain();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_mode(input logic [1:0] m);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int start;
		arst_n         = 1'b0;
		byte_valid     = 1'b0;
		byte_item      = '0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		lit_armed      = 1'b0;
		lit_token      = '0;
		mismatch_count = 0;
		items_sent     = 0;
		send_idle_pct  = 0;
		stall_pct      = 0;
		hold_left      = 0;
		fmt_mode       = MODE_WORD32;
		clear_partial();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_CFG) begin
				wait_drain();
				set_mode(dir_table[i].value[1:0]);
			end else begin
				for (int k = 0; k < dir_table[i].reps; k++)
					send_byte(dir_table[i].value, dir_table[i].eoi,
						dir_table[i].has_lit && k == dir_table[i].reps - 1,
						dir_table[i].lit_st);
			end
		end

		for (int p = 0; p < 8; p++) begin
			wait_drain();
			send_idle_pct = phase_idle[p % 4];
			stall_pct     = phase_stall[p % 4];
			// with neither idling nor random stalls, hold the receiver off so the input side backs up
			if (send_idle_pct == 0 && stall_pct == 0)
				hold_left = HOLD_CYCLES;
			set_mode(phase_mode[p]);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				if ($urandom_range(19) == 0) begin
					send_eoi();
				end else begin
					case (phase_mode[p])
						MODE_WORD32:  send_word_token(4);
						MODE_WORD64:  send_word_token(8);
						MODE_VARBYTE: send_varbyte_token();
						default: begin
							if ($urandom_range(7) == 0)
								send_eoi();
							else
								send_data(rand_byte());
						end
					endcase
				end
			end
			// send one to three stray bytes; a partial token they leave is for the next mode write to drop
			repeat ($urandom_range(1, 3)) send_data(rand_byte());
		end

		wait_drain();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#(2 * CLK_HALF * 400000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/rlztd_pkg.sv
rtl/core/rlz_token_stream_decoder_unit.sv
test/tb_rlz_token_stream_decoder_unit.sv
